// File: design/mts_pkg.sv
// ----------------------------------------------------------------------------
// mts_pkg
// Shared codes and control types of the min-tracking stack.
// ----------------------------------------------------------------------------
package mts_pkg;

    localparam int unsigned OUT_BITS = 31;

    localparam logic [1:0] CMD_PUSH  = 2'd0;
    localparam logic [1:0] CMD_POP   = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_val;  // capture the pushed value
        logic wr_min;    // write the current minimum at the fill point
        logic wr_val;    // write the captured value at the fill point
        logic set_min;   // with wr_val: the value becomes the minimum
        logic dec;       // drop one entry and read the entry that becomes the new top
        logic take_min;  // minimum from read data
        logic take_top;  // top from read data
        logic load_out;  // register a result from the next state
        logic ovf;       // the result reports a dropped push
    } t_ctrl;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic empty;
        logic one_left;
        logic le_min;     // offered value is no greater than the minimum
        logic fit1;
        logic fit2;
        logic top_is_min;
        logic out_free;
    } t_stat;

endpackage

// File: design/min_tracking_stack_unit.sv
// ----------------------------------------------------------------------------
// min_tracking_stack_unit
// LIFO stack that reports its top and running minimum after every item.
// ----------------------------------------------------------------------------
// Each item is a push, a pop or a query and returns one result. A query, a
// dropped push and a pop of an empty stack or of its last entry end in S_IDLE;
// a push goes on to S_PUSH_VAL, an ordinary pop to S_POP_TOP, a pop of the
// minimum that restores a saved one to S_POP_MIN then S_POP_TOP, or only to
// S_POP_MIN if it empties the stack. The steps follow the single-port stack
// memory: one write or one registered read per cycle. The result sits in an
// output register; a new item is taken once the last item is done and its
// result is taken or being taken. The memory needs no clearing after reset.
module min_tracking_stack_unit import mts_pkg::*; #(
    parameter int unsigned STORE_DEPTH = 1024,
    parameter int unsigned VALUE_BITS  = 30
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [1:0]                 i_cmd,
    input  logic [VALUE_BITS-1:0]      i_push_value,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic signed [OUT_BITS-1:0] o_top_value,
    output logic signed [OUT_BITS-1:0] o_min_value,
    output logic                       o_is_empty,
    output logic                       o_overflow
);

    t_ctrl ctrl;
    t_stat stat;

    mts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_cmd      (i_cmd),
        .i_stat     (stat),
        .o_in_ready (o_in_ready),
        .o_ctrl     (ctrl)
    );

    mts_dpath #(
        .STORE_DEPTH (STORE_DEPTH),
        .VALUE_BITS  (VALUE_BITS)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_value (i_push_value),
        .i_ctrl       (ctrl),
        .i_out_ready  (i_out_ready),
        .o_stat       (stat),
        .o_out_valid  (o_out_valid),
        .o_top_value  (o_top_value),
        .o_min_value  (o_min_value),
        .o_is_empty   (o_is_empty),
        .o_overflow   (o_overflow)
    );

endmodule

// File: design/mts_ctrl.sv
// ----------------------------------------------------------------------------
// mts_ctrl
// Sequencer that turns each accepted item into datapath steps.
// ----------------------------------------------------------------------------
module mts_ctrl import mts_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_cmd,
    input  t_stat      i_stat,
    output logic       o_in_ready,
    output t_ctrl      o_ctrl
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_PUSH_VAL,
        S_POP_MIN,
        S_POP_TOP
    } t_state;

    t_state r_state, n_state;
    logic   r_set_min, n_set_min;
    logic   save;
    logic   accept;

    assign o_in_ready = (r_state == S_IDLE) && i_stat.out_free;
    assign accept     = o_in_ready && i_in_valid;
    assign save       = !i_stat.empty && i_stat.le_min;

    always_comb begin
        n_state   = r_state;
        n_set_min = r_set_min;
        o_ctrl    = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_cmd)
                        CMD_PUSH: begin
                            if (save ? !i_stat.fit2 : !i_stat.fit1) begin
                                o_ctrl.load_out = 1'b1;
                                o_ctrl.ovf      = 1'b1;
                            end else begin
                                // A push at or below the minimum first saves the old one.
                                o_ctrl.load_val = 1'b1;
                                o_ctrl.wr_min   = save;
                                n_set_min       = save || i_stat.empty;
                                n_state         = S_PUSH_VAL;
                            end
                        end
                        CMD_POP: begin
                            if (i_stat.empty) begin
                                o_ctrl.load_out = 1'b1;
                            end else begin
                                o_ctrl.dec = 1'b1;
                                if (i_stat.one_left) begin
                                    o_ctrl.load_out = 1'b1;
                                end else if (i_stat.top_is_min) begin
                                    n_state = S_POP_MIN;
                                end else begin
                                    n_state = S_POP_TOP;
                                end
                            end
                        end
                        CMD_QUERY: begin
                            o_ctrl.load_out = 1'b1;
                        end
                        default: begin
                            o_ctrl.load_out = 1'b1;
                        end
                    endcase
                end
            end
            S_PUSH_VAL: begin
                o_ctrl.wr_val   = 1'b1;
                o_ctrl.set_min  = r_set_min;
                o_ctrl.load_out = 1'b1;
                n_state         = S_IDLE;
            end
            S_POP_MIN: begin
                // The saved minimum is removed as well.
                o_ctrl.take_min = 1'b1;
                o_ctrl.dec      = 1'b1;
                if (i_stat.one_left) begin
                    o_ctrl.load_out = 1'b1;
                    n_state         = S_IDLE;
                end else begin
                    n_state = S_POP_TOP;
                end
            end
            S_POP_TOP: begin
                o_ctrl.take_top = 1'b1;
                o_ctrl.load_out = 1'b1;
                n_state         = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_set_min <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_set_min <= n_set_min;
        end
    end

endmodule

// File: design/mts_dpath.sv
// ----------------------------------------------------------------------------
// mts_dpath
// Stack memory, fill count, cached top and minimum, and the result register.
// ----------------------------------------------------------------------------
module mts_dpath import mts_pkg::*; #(
    parameter int unsigned STORE_DEPTH = 1024,
    parameter int unsigned VALUE_BITS  = 30
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [VALUE_BITS-1:0]      i_push_value,
    input  t_ctrl                      i_ctrl,
    input  logic                       i_out_ready,
    output t_stat                      o_stat,
    output logic                       o_out_valid,
    output logic signed [OUT_BITS-1:0] o_top_value,
    output logic signed [OUT_BITS-1:0] o_min_value,
    output logic                       o_is_empty,
    output logic                       o_overflow
);

    localparam int unsigned AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(STORE_DEPTH + 1);
    localparam int unsigned XW = (VALUE_BITS > OUT_BITS) ? VALUE_BITS : OUT_BITS;

    logic [VALUE_BITS-1:0] mem [STORE_DEPTH];

    logic [CW-1:0]         r_fill, n_fill;
    logic [VALUE_BITS-1:0] r_min, n_min;
    logic [VALUE_BITS-1:0] r_top, n_top;
    logic [VALUE_BITS-1:0] r_val;
    logic [VALUE_BITS-1:0] r_rd;
    logic                  r_out_valid;
    logic [CW-1:0]         rd_ptr;
    logic [AW-1:0]         rd_addr;
    logic                  wr_en;
    logic [VALUE_BITS-1:0] wr_data;
    logic                  n_empty;
    logic [XW-1:0]         top_ext;
    logic [XW-1:0]         min_ext;

    assign rd_ptr  = r_fill - CW'(2);
    assign rd_addr = rd_ptr[AW-1:0];
    assign wr_en   = i_ctrl.wr_min || i_ctrl.wr_val;
    assign wr_data = i_ctrl.wr_min ? r_min : r_val;

    always_comb begin
        n_fill = r_fill;
        n_min  = r_min;
        n_top  = r_top;
        if (wr_en) begin
            n_fill = r_fill + CW'(1);
        end else if (i_ctrl.dec) begin
            n_fill = r_fill - CW'(1);
        end
        if (i_ctrl.wr_val) begin
            n_top = r_val;
        end else if (i_ctrl.take_top) begin
            n_top = r_rd;
        end
        if (i_ctrl.wr_val && i_ctrl.set_min) begin
            n_min = r_val;
        end else if (i_ctrl.take_min) begin
            n_min = r_rd;
        end
    end

    assign n_empty = (n_fill == '0);
    assign top_ext = XW'(n_top);
    assign min_ext = XW'(n_min);

    assign o_stat.empty      = (r_fill == '0);
    assign o_stat.one_left   = (r_fill == CW'(1));
    assign o_stat.le_min     = (i_push_value <= r_min);
    assign o_stat.fit1       = (r_fill != CW'(STORE_DEPTH));
    assign o_stat.fit2       = (r_fill < CW'(STORE_DEPTH - 1));
    assign o_stat.top_is_min = (r_top == r_min);
    assign o_stat.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;

    // Single-port memory: one write or one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_fill[AW-1:0]] <= wr_data;
        end else begin
            r_rd <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_min       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_fill <= n_fill;
            r_min  <= n_min;
            if (i_ctrl.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_top <= n_top;
        if (i_ctrl.load_val) begin
            r_val <= i_push_value;
        end
        if (i_ctrl.load_out) begin
            o_top_value <= n_empty ? '1 : top_ext[OUT_BITS-1:0];
            o_min_value <= n_empty ? '1 : min_ext[OUT_BITS-1:0];
            o_is_empty  <= n_empty;
            o_overflow  <= i_ctrl.ovf;
        end
    end

endmodule

// File: tb/min_stack_checker.sv
// ----------------------------------------------------------------------------
// min_stack_checker
// Watches both channels of the min-tracking stack and checks every result.
// ----------------------------------------------------------------------------
// Each accepted input item is run through a behavioural copy of the stack,
// and the result it should produce is queued. Each accepted result is then
// compared field by field with the oldest queued result. The number of
// mismatches and of results still awaited are handed to the testbench top.
module min_stack_checker import mts_pkg::*; #(
    parameter int unsigned STORE_DEPTH = 1024,
    parameter int unsigned VALUE_BITS  = 30
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_ready,
    input  logic [1:0]                 i_cmd,
    input  logic [VALUE_BITS-1:0]      i_push_value,
    input  logic                       i_out_valid,
    input  logic                       i_out_ready,
    input  logic signed [OUT_BITS-1:0] i_top_value,
    input  logic signed [OUT_BITS-1:0] i_min_value,
    input  logic                       i_is_empty,
    input  logic                       i_overflow,
    output int                         o_fail_count,
    output int                         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] top_value;
        logic signed [OUT_BITS-1:0] min_value;
        logic                       is_empty;
        logic                       overflow;
    } t_stack_result;

    logic [VALUE_BITS-1:0] stack_mem [STORE_DEPTH];
    int unsigned           depth_cnt;
    logic [VALUE_BITS-1:0] run_min;
    t_stack_result         awaited_results[$];
    int                    mismatch_cnt;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        mismatch_cnt = 0;
        depth_cnt    = 0;
        run_min      = '0;
    end

    // Applies one item to the shadow stack and returns the result it causes.
    task automatic apply_stack_op(input logic [1:0] op, input logic [VALUE_BITS-1:0] val,
                                  output t_stack_result res);
        logic                  save;
        logic                  dropped;
        int unsigned           need;
        logic [VALUE_BITS-1:0] popped;
        dropped = 1'b0;
        case (op)
            CMD_PUSH: begin
                save = (depth_cnt != 0) && (val <= run_min);
                need = save ? 2 : 1;
                if (depth_cnt + need > STORE_DEPTH) begin
                    dropped = 1'b1;
                end else begin
                    if (depth_cnt == 0) begin
                        run_min = val;
                    end else if (save) begin
                        // The old minimum goes beneath the new value.
                        stack_mem[depth_cnt] = run_min;
                        depth_cnt++;
                        run_min = val;
                    end
                    stack_mem[depth_cnt] = val;
                    depth_cnt++;
                end
            end
            CMD_POP: begin
                if (depth_cnt != 0) begin
                    popped = stack_mem[depth_cnt-1];
                    depth_cnt--;
                    if (popped == run_min && depth_cnt != 0) begin
                        run_min = stack_mem[depth_cnt-1];
                        depth_cnt--;
                    end
                end
            end
            default: begin
            end
        endcase
        if (depth_cnt == 0) begin
            res.top_value = '1;
            res.min_value = '1;
            res.is_empty  = 1'b1;
        end else begin
            res.top_value = OUT_BITS'(stack_mem[depth_cnt-1]);
            res.min_value = OUT_BITS'(run_min);
            res.is_empty  = 1'b0;
        end
        res.overflow = dropped;
    endtask

    task automatic report_mismatch(input string what, input logic signed [31:0] got,
                                   input logic signed [31:0] want);
        mismatch_cnt++;
        $display("%0t ns: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    always @(posedge i_clk) begin
        t_stack_result predicted;
        t_stack_result oldest;
        if (!i_rst_n) begin
            depth_cnt = 0;
            run_min   = '0;
            awaited_results.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                apply_stack_op(i_cmd, i_push_value, predicted);
                awaited_results.push_back(predicted);
            end
            if (i_out_valid && i_out_ready) begin
                if (awaited_results.size() == 0) begin
                    report_mismatch("result with no item outstanding", 0, 0);
                end else begin
                    oldest = awaited_results.pop_front();
                    if (i_top_value !== oldest.top_value)
                        report_mismatch("top_value", i_top_value, oldest.top_value);
                    if (i_min_value !== oldest.min_value)
                        report_mismatch("min_value", i_min_value, oldest.min_value);
                    if (i_is_empty !== oldest.is_empty)
                        report_mismatch("is_empty", {31'd0, i_is_empty}, {31'd0, oldest.is_empty});
                    if (i_overflow !== oldest.overflow)
                        report_mismatch("overflow", {31'd0, i_overflow}, {31'd0, oldest.overflow});
                end
            end
        end
        o_fail_count <= mismatch_cnt;
        o_pending    <= awaited_results.size();
    end

endmodule

// File: tb/tb_min_tracking_stack_unit.sv
// ----------------------------------------------------------------------------
// tb_min_tracking_stack_unit
// Stimulus and verdict for the min-tracking stack.
// ----------------------------------------------------------------------------
// A short directed sequence covers the empty stack, equal and smaller pushes
// that save the minimum, pops that restore it and the spare command code. The
// stack is then filled to the last slot and beyond to provoke both kinds of
// dropped push, and drained again. Random items follow, with random gaps on
// the input side and random back-pressure on the output side, except near
// the end. The checker beside the block does all the comparing.
module tb_min_tracking_stack_unit import mts_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned STORE_DEPTH  = 1024;
    localparam int unsigned VALUE_BITS   = 30;
    localparam logic [VALUE_BITS-1:0] VALUE_MAX = '1;
    localparam logic [1:0]  CMD_SPARE    = 2'd3;
    localparam int unsigned RANDOM_ITEMS = 600;
    localparam int unsigned CALM_ITEMS   = 100;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       in_valid;
    logic                       in_ready;
    logic [1:0]                 cmd;
    logic [VALUE_BITS-1:0]      push_value;
    logic                       out_valid;
    logic                       out_ready;
    logic signed [OUT_BITS-1:0] top_value;
    logic signed [OUT_BITS-1:0] min_value;
    logic                       is_empty;
    logic                       overflow;
    int                         fail_count;
    int                         pending;

    bit                         idle_on;
    logic [VALUE_BITS-1:0]      last_push;

    min_tracking_stack_unit #(
        .STORE_DEPTH (STORE_DEPTH),
        .VALUE_BITS  (VALUE_BITS)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_cmd        (cmd),
        .i_push_value (push_value),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_top_value  (top_value),
        .o_min_value  (min_value),
        .o_is_empty   (is_empty),
        .o_overflow   (overflow)
    );

    min_stack_checker #(
        .STORE_DEPTH (STORE_DEPTH),
        .VALUE_BITS  (VALUE_BITS)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_cmd        (cmd),
        .i_push_value (push_value),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_top_value  (top_value),
        .i_min_value  (min_value),
        .i_is_empty   (is_empty),
        .i_overflow   (overflow),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [VALUE_BITS-1:0] any_value();
        return VALUE_BITS'($urandom);
    endfunction

    // Offers one item, after an optional gap, and returns once it is taken.
    task automatic send_item(input logic [1:0] op, input logic [VALUE_BITS-1:0] val);
        int unsigned gap;
        gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid   <= 1'b1;
        cmd        <= op;
        push_value <= val;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
    endtask

    task automatic run_directed();
        send_item(CMD_QUERY, any_value());
        send_item(CMD_POP, any_value());
        send_item(CMD_SPARE, any_value());
        send_item(CMD_PUSH, VALUE_MAX);
        send_item(CMD_PUSH, VALUE_MAX);
        send_item(CMD_PUSH, '0);
        send_item(CMD_PUSH, '0);
        send_item(CMD_PUSH, VALUE_BITS'(5));
        send_item(CMD_QUERY, VALUE_MAX);
        send_item(CMD_POP, '0);
        send_item(CMD_POP, VALUE_MAX);
        send_item(CMD_POP, any_value());
        send_item(CMD_POP, any_value());
        // The last entry is the minimum itself, so nothing is restored.
        send_item(CMD_POP, any_value());
        send_item(CMD_POP, any_value());
        send_item(CMD_PUSH, VALUE_BITS'(7));
        send_item(CMD_PUSH, VALUE_BITS'(9));
        send_item(CMD_POP, any_value());
        send_item(CMD_POP, any_value());
        send_item(CMD_PUSH, VALUE_BITS'(30'h2AAA_AAAA));
        send_item(CMD_PUSH, VALUE_BITS'(30'h1555_5555));
        send_item(CMD_SPARE, VALUE_BITS'(30'h0F0F_0F0F));
        send_item(CMD_POP, any_value());
        send_item(CMD_POP, any_value());
    endtask

    // Every push after the first saves the minimum, so each takes two slots
    // and the store ends one slot short of full.
    task automatic fill_and_drain();
        logic [VALUE_BITS-1:0] v;
        v = VALUE_MAX - VALUE_BITS'($urandom_range(256, 4096));
        send_item(CMD_PUSH, v);
        repeat (STORE_DEPTH / 2 - 1) begin
            v = v - VALUE_BITS'($urandom_range(0, 3));
            send_item(CMD_PUSH, v);
        end
        send_item(CMD_PUSH, v - VALUE_BITS'($urandom_range(0, 7)));
        send_item(CMD_PUSH, VALUE_MAX);
        send_item(CMD_PUSH, v + VALUE_BITS'($urandom_range(1, 100)));
        send_item(CMD_PUSH, v);
        send_item(CMD_QUERY, any_value());
        repeat (STORE_DEPTH / 2 + 3) send_item(CMD_POP, any_value());
    endtask

    task automatic run_random();
        logic [1:0]            op;
        logic [VALUE_BITS-1:0] v;
        int unsigned           pick;
        for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS - CALM_ITEMS)
                idle_on = 1'b0;
            pick = $urandom_range(0, 99);
            if (pick < 45)
                op = CMD_PUSH;
            else if (pick < 80)
                op = CMD_POP;
            else if (pick < 92)
                op = CMD_QUERY;
            else
                op = CMD_SPARE;
            case ($urandom_range(0, 3))
                0: v = any_value();
                1: v = VALUE_BITS'($urandom_range(0, 7));
                2: v = ($urandom_range(0, 1) != 0) ? VALUE_MAX : '0;
                default: v = last_push + VALUE_BITS'($urandom_range(0, 4)) - VALUE_BITS'(2);
            endcase
            if (op == CMD_PUSH)
                last_push = v;
            send_item(op, v);
        end
    endtask

    // Output back-pressure in short bursts.
    initial begin
        @(posedge i_clk);
        forever begin
            if (idle_on && $urandom_range(0, 2) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    end

    initial begin
        in_valid   <= 1'b0;
        cmd        <= CMD_QUERY;
        push_value <= '0;
        out_ready  <= 1'b0;
        i_rst_n    <= 1'b0;
        idle_on    = 1'b1;
        last_push  = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed();
        fill_and_drain();
        run_random();
        in_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        // Every result must also have arrived by now.
        if (fail_count == 0 && pending == 0) begin
            $display("tb_min_tracking_stack_unit: PASS");
        end else begin
            $display("tb_min_tracking_stack_unit: FAIL");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("tb_min_tracking_stack_unit: FAIL");
        $finish;
    end

endmodule

// File: files.f
design/mts_pkg.sv
design/mts_ctrl.sv
design/mts_dpath.sv
design/min_tracking_stack_unit.sv
tb/min_stack_checker.sv
tb/tb_min_tracking_stack_unit.sv
